/* rtl/core/bvs_pkg.sv */
// Shared types and constants for the bounded value stack.
`default_nettype none

package bvs_pkg;

  localparam int WORD_W          = 64;
  localparam int DEPTH_W         = 8;
  localparam int STACK_DEPTH_DEF = 128;

  // Request actions
  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_DUP   = 3'd3,
    ACT_SWAP  = 3'd4,
    ACT_CLEAR = 3'd5
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FEW   = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_REFILL = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_value;
    logic [1:0]         status;
    logic [DEPTH_W-1:0] depth;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/bvs_stream_if.sv */
// Valid/ready channel carrying one payload word.
`default_nettype none

interface bvs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/bounded_value_stack_unit.sv */
// Bounded value stack: top level joining the controller and the stack store.
//
// A request word on req carries an action (push, pop, peek, duplicate, swap
// top two, clear) and a 64-bit push value. Each accepted request gives exactly
// one response word on rsp: read data, a status code and the depth after the
// request. Both channels use valid/ready; a word moves when both are high.
//
// The top entry is held in a register and the rest in a single-port memory,
// so the response is registered at the edge that accepts the request. Push,
// peek, duplicate, clear and every failing request need no further step. A
// pop that leaves entries behind, and a successful swap, go on to a refill
// state that loads the top register from the memory's read port (and, for a
// swap, writes the old top back through the same port).
//
// Reset (rst, synchronous) empties the stack and drops any pending response;
// no clearing pass runs and memory contents are left as they are. If rsp is
// stalled the response holds and req is taken again only once that response
// is taken in the same cycle or has gone.
`default_nettype none

module bounded_value_stack_unit import bvs_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  bvs_stream_if.sink   req,
  bvs_stream_if.source rsp
);

  localparam int CW       = $clog2(STACK_DEPTH + 1);
  localparam int MEM_WORDS = STACK_DEPTH - 1;
  localparam int AW       = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic              mem_en;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  bvs_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  bvs_mem #(
    .WORDS (MEM_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  // a full status always reports the full depth
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.payload.status == ST_FULL) |->
      rsp.payload.depth == DEPTH_W'(STACK_DEPTH))
    else $error("full status with depth not at capacity");

  // an empty status leaves no entries and no data
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.payload.status == ST_EMPTY) |->
      (rsp.payload.depth == '0) && (rsp.payload.read_value == '0))
    else $error("empty status with entries or data");

  // only pop and peek return data
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.payload.action != ACT_POP) &&
      (req.payload.action != ACT_PEEK) |=> rsp.payload.read_value == '0)
    else $error("read data on an action that returns none");

  // a successful swap holds off the next request while the top refills
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.payload.action == ACT_SWAP) |=>
      (rsp.payload.status != ST_OK) || !req.ready)
    else $error("request taken during swap refill");
`endif

endmodule

`default_nettype wire

/* rtl/core/bvs_mem.sv */
// Single-port stack store with registered read data.
`default_nettype none

module bvs_mem import bvs_pkg::*; #(
  parameter int WORDS = STACK_DEPTH_DEF - 1,
  parameter int AW    = 7
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [WORD_W-1:0] wdata,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] store [WORDS];

  // write, or read into the registered rdata
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        store[addr] <= wdata;
      end else begin
        rdata <= store[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bvs_ctrl.sv */
// Stack controller: entry count, top-of-stack register, sequencing and result register.
`default_nettype none

module bvs_ctrl import bvs_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int CW          = 8,
  parameter int AW          = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  bvs_stream_if.sink             req,
  bvs_stream_if.source           rsp,
  output logic                   mem_en,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_addr,
  output logic      [WORD_W-1:0] mem_wdata,
  input  wire logic [WORD_W-1:0] mem_rdata
);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [WORD_W-1:0] top, top_next;
  logic              refill_swap;
  logic [AW-1:0]     refill_addr;
  logic              rsp_valid;
  rsp_t              rsp_word;

  logic              accept;
  logic              refill_start;
  logic              swap_start;
  logic [WORD_W-1:0] rd;
  status_t           st;
  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic              is_empty, is_full;

  assign cnt_m1   = count - CW'(1);
  assign cnt_m2   = count - CW'(2);
  assign is_empty = (count == '0);
  assign is_full  = (count == CW'(STACK_DEPTH));

  // take a word only when idle and the result register is free or draining
  assign req.ready   = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept      = req.valid && req.ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_word;

  // datapath: the top word lives in a register, entries below it in memory
  always_comb begin
    count_next   = count;
    top_next     = top;
    rd           = '0;
    st           = ST_OK;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = cnt_m1[AW-1:0];
    mem_wdata    = top;
    refill_start = 1'b0;
    swap_start   = 1'b0;
    if (state == S_REFILL) begin
      // new top from memory; a swap also writes the old top back down
      top_next = mem_rdata;
      if (refill_swap) begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = refill_addr;
      end
    end else if (accept) begin
      unique case (action_t'(req.payload.action))
        ACT_PUSH: begin
          if (is_full) begin
            st = ST_FULL;
          end else begin
            mem_en     = !is_empty;
            mem_we     = 1'b1;
            top_next   = req.payload.push_value;
            count_next = count + CW'(1);
          end
        end
        ACT_POP: begin
          if (is_empty) begin
            st = ST_EMPTY;
          end else begin
            rd         = top;
            count_next = cnt_m1;
            if (count > CW'(1)) begin
              mem_en       = 1'b1;
              mem_addr     = cnt_m2[AW-1:0];
              refill_start = 1'b1;
            end
          end
        end
        ACT_PEEK: begin
          if (is_empty) begin
            st = ST_EMPTY;
          end else begin
            rd = top;
          end
        end
        ACT_DUP: begin
          if (is_empty) begin
            st = ST_EMPTY;
          end else if (is_full) begin
            st = ST_FULL;
          end else begin
            mem_en     = 1'b1;
            mem_we     = 1'b1;
            count_next = count + CW'(1);
          end
        end
        ACT_SWAP: begin
          if (count < CW'(2)) begin
            st = ST_FEW;
          end else begin
            mem_en       = 1'b1;
            mem_addr     = cnt_m2[AW-1:0];
            refill_start = 1'b1;
            swap_start   = 1'b1;
          end
        end
        ACT_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (refill_start) state_next = S_REFILL;
      S_REFILL: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top <= top_next;
    if (refill_start) begin
      refill_swap <= swap_start;
      refill_addr <= cnt_m2[AW-1:0];
    end
    if (accept) begin
      rsp_word.read_value <= rd;
      rsp_word.status     <= st;
      rsp_word.depth      <= DEPTH_W'(count_next);
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the bounded value stack unit.
`timescale 1ns / 100ps

module testbench;
  import bvs_pkg::*;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 90;
  localparam int SEGMENT_LEN = 15;

  // Action codes the block treats as no-ops
  localparam logic [2:0] ACT_NOP_A = 3'd6;
  localparam logic [2:0] ACT_NOP_B = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic clk;
  logic rst;

  bvs_stream_if #(.payload_t(req_t)) req_ch ();
  bvs_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  bounded_value_stack_unit #(.STACK_DEPTH(STACK_DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted stack contents and fill level
  logic [WORD_W-1:0] stack_words [STACK_DEPTH];
  int                stack_fill;
  rsp_t              pending_results [$];

  int   error_count;
  int   cycle_count;
  bit   idle_on;
  bit   hold_ask;

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Expected result of one request; updates the predicted stack
  function automatic rsp_t predict_stack_result(input req_t rq);
    rsp_t              r;
    logic [WORD_W-1:0] t;
    r.read_value = '0;
    r.status     = ST_OK;
    case (rq.action)
      ACT_PUSH: begin
        if (stack_fill >= STACK_DEPTH) r.status = ST_FULL;
        else begin
          stack_words[stack_fill] = rq.push_value;
          stack_fill++;
        end
      end
      ACT_POP: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else begin
          stack_fill--;
          r.read_value = stack_words[stack_fill];
        end
      end
      ACT_PEEK: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else r.read_value = stack_words[stack_fill-1];
      end
      ACT_DUP: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else if (stack_fill >= STACK_DEPTH) r.status = ST_FULL;
        else begin
          stack_words[stack_fill] = stack_words[stack_fill-1];
          stack_fill++;
        end
      end
      ACT_SWAP: begin
        if (stack_fill < 2) r.status = ST_FEW;
        else begin
          t = stack_words[stack_fill-1];
          stack_words[stack_fill-1] = stack_words[stack_fill-2];
          stack_words[stack_fill-2] = t;
        end
      end
      ACT_CLEAR: stack_fill = 0;
      default: ;
    endcase
    r.depth = DEPTH_W'(stack_fill);
    return r;
  endfunction

  // Check each response word, then record the expectation of each request word
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected response: expected none, got %h/%0d/%0d", $time,
                   got.read_value, got.status, got.depth);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h, got %h", $time,
                     want.read_value, got.read_value);
            error_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            error_count++;
          end
          if (got.depth !== want.depth) begin
            $display("%0t: depth expected %0d, got %0d", $time, want.depth, got.depth);
            error_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        pending_results.push_back(predict_stack_result(req_ch.payload));
    end
  end

  // Response side: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request word; returns at the falling edge after it is taken
  task automatic send_word(input logic [2:0] act, input logic [WORD_W-1:0] val);
    req_t w;
    int   gap;
    w.action     = act;
    w.push_value = val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h7FF0_0000_0000_0000; // +inf
      3: return 64'h8000_0000_0000_0000; // negative zero
      4: return 64'h7FF8_0000_0000_0001; // quiet NaN with payload
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [2:0] pick_action(input mix_t mix);
    int p_push;
    int p_pop;
    int p_dup;
    int roll;
    case (mix)
      MIX_FILL:  begin p_push = 55; p_pop = 10; p_dup = 14; end
      MIX_DRAIN: begin p_push = 15; p_pop = 52; p_dup = 6;  end
      default:   begin p_push = 32; p_pop = 30; p_dup = 10; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < p_push) return ACT_PUSH;
    roll -= p_push;
    if (roll < p_pop) return ACT_POP;
    roll -= p_pop;
    if (roll < p_dup) return ACT_DUP;
    roll -= p_dup;
    if (roll < 8) return ACT_PEEK;
    roll -= 8;
    if (roll < 10) return ACT_SWAP;
    roll -= 10;
    if (roll < 1) return ACT_CLEAR;
    return ($urandom_range(0, 1) != 0) ? ACT_NOP_B : ACT_NOP_A;
  endfunction

  // Every action but push on an empty stack, including the unused codes
  task automatic test_empty_cases();
    send_word(ACT_POP, '1);
    send_word(ACT_PEEK, '0);
    send_word(ACT_DUP, '1);
    send_word(ACT_SWAP, '0);
    send_word(ACT_NOP_A, '1);
    send_word(ACT_NOP_B, 64'h0123_4567_89AB_CDEF);
    send_word(ACT_CLEAR, '1);
  endtask

  // Short sequences through each action with extreme words
  task automatic test_basic_ops();
    send_word(ACT_PUSH, '0);
    send_word(ACT_SWAP, '1);        // one entry only
    send_word(ACT_PUSH, '1);
    send_word(ACT_PEEK, '0);
    send_word(ACT_SWAP, '0);
    send_word(ACT_PEEK, '1);
    send_word(ACT_DUP, '0);
    send_word(ACT_POP, '1);
    send_word(ACT_POP, '0);
    send_word(ACT_POP, '1);
    send_word(ACT_POP, '0);         // pop on an empty stack
    send_word(ACT_PUSH, 64'h7FF0_0000_0000_0000);
    send_word(ACT_PUSH, 64'h8000_0000_0000_0000);
    send_word(ACT_CLEAR, '0);
    send_word(ACT_PEEK, '1);
  endtask

  // Fill to capacity under a long response hold-off, hit the full cases, drain
  task automatic test_full_stack();
    int i;
    send_word(ACT_CLEAR, rand_word());
    hold_ask = 1'b1;
    for (i = 0; i < STACK_DEPTH; i++) send_word(ACT_PUSH, rand_word());
    send_word(ACT_PUSH, '1);        // full
    send_word(ACT_DUP, '0);         // full
    send_word(ACT_PEEK, rand_word());
    send_word(ACT_SWAP, rand_word());
    send_word(ACT_POP, rand_word());
    send_word(ACT_DUP, rand_word());
    send_word(ACT_DUP, rand_word()); // full again
    send_word(ACT_SWAP, rand_word());
    for (i = 0; i <= STACK_DEPTH; i++) send_word(ACT_POP, rand_word());
    for (i = 0; i < 20; i++) send_word(ACT_PUSH, rand_word());
    send_word(ACT_CLEAR, rand_word());
    wait_for_results();
  endtask

  // Random mixes in segments, each with its own bias and idling
  task automatic test_random_mix();
    int   i;
    int   roll;
    mix_t mix;
    mix = MIX_FILL;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT_LEN == 0) begin
        roll = $urandom_range(0, 3);
        if (stack_fill < STACK_DEPTH / 2) mix = (roll < 3) ? MIX_FILL : MIX_EVEN;
        else mix = (roll < 2) ? MIX_DRAIN : ((roll == 2) ? MIX_FILL : MIX_EVEN);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_word(pick_action(mix), rand_word());
    end
    idle_on = 1'b1;
    wait_for_results();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_back_to_back();
    int i;
    idle_on = 1'b0;
    for (i = 0; i < 60; i++) send_word(pick_action(MIX_EVEN), rand_word());
    wait_for_results();
  endtask

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    idle_on        = 1'b1;
    hold_ask       = 1'b0;
    stack_fill     = 0;
    error_count    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_cases();
    test_basic_ops();
    test_full_stack();
    test_random_mix();
    test_back_to_back();

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
